// ===== hw/rtl/fmop_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-operator FM channel package
// Shared widths, operator request type and the log-sine and exp tables.
// ---------------------------------------------------------------------------
package fmop_pkg;

    localparam int CHANNELS_DEF = 9;

    localparam int CHAN_W      = 4;
    localparam int CHAN_CMP_W  = 5;
    localparam int PHASE_W     = 10;
    localparam int ATTEN_IN_W  = 9;
    localparam int LFO_W       = 4;
    localparam int FB_W        = 3;
    localparam int ATTEN_SUM_W = 10;
    localparam int ATTEN_W     = 7;
    localparam int LSIN_W      = 12;
    localparam int EXP_W       = 11;
    localparam int LOG_SUM_W   = 13;
    localparam int MAG_W       = 13;
    localparam int OP_OUT_W    = 14;
    localparam int FB_SUM_W    = 15;
    localparam int SAMPLE_W    = 9;
    localparam int SAMPLE_LSB  = 5;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    localparam logic [ATTEN_W-1:0] ATTEN_MAX     = 7'd127;
    localparam logic [LSIN_W-1:0]  LSIN_SILENT   = 12'hFFF;
    localparam logic [3:0]         FB_SHIFT_BASE = 4'd10;

    typedef struct packed {
        logic [PHASE_W-1:0]     phase;
        logic [PHASE_W-1:0]     offset;
        logic [ATTEN_SUM_W-1:0] atten;
        logic                   half_sine;
    } op_req_t;

    typedef logic [LSIN_W-1:0] logsin_rom_t [256];
    typedef logic [EXP_W-1:0]  exp_rom_t [256];

    localparam logsin_rom_t LOGSIN_ROM = '{
        12'h859,12'h6c3,12'h607,12'h58b,12'h52e,12'h4e4,12'h4a6,12'h471,
        12'h443,12'h41a,12'h3f5,12'h3d3,12'h3b5,12'h398,12'h37e,12'h365,
        12'h34e,12'h339,12'h324,12'h311,12'h2ff,12'h2ed,12'h2dc,12'h2cd,
        12'h2bd,12'h2af,12'h2a0,12'h293,12'h286,12'h279,12'h26d,12'h261,
        12'h256,12'h24b,12'h240,12'h236,12'h22c,12'h222,12'h218,12'h20f,
        12'h206,12'h1fd,12'h1f5,12'h1ec,12'h1e4,12'h1dc,12'h1d4,12'h1cd,
        12'h1c5,12'h1be,12'h1b7,12'h1b0,12'h1a9,12'h1a2,12'h19b,12'h195,
        12'h18f,12'h188,12'h182,12'h17c,12'h177,12'h171,12'h16b,12'h166,
        12'h160,12'h15b,12'h155,12'h150,12'h14b,12'h146,12'h141,12'h13c,
        12'h137,12'h133,12'h12e,12'h129,12'h125,12'h121,12'h11c,12'h118,
        12'h114,12'h10f,12'h10b,12'h107,12'h103,12'h0ff,12'h0fb,12'h0f8,
        12'h0f4,12'h0f0,12'h0ec,12'h0e9,12'h0e5,12'h0e2,12'h0de,12'h0db,
        12'h0d7,12'h0d4,12'h0d1,12'h0cd,12'h0ca,12'h0c7,12'h0c4,12'h0c1,
        12'h0be,12'h0bb,12'h0b8,12'h0b5,12'h0b2,12'h0af,12'h0ac,12'h0a9,
        12'h0a7,12'h0a4,12'h0a1,12'h09f,12'h09c,12'h099,12'h097,12'h094,
        12'h092,12'h08f,12'h08d,12'h08a,12'h088,12'h086,12'h083,12'h081,
        12'h07f,12'h07d,12'h07a,12'h078,12'h076,12'h074,12'h072,12'h070,
        12'h06e,12'h06c,12'h06a,12'h068,12'h066,12'h064,12'h062,12'h060,
        12'h05e,12'h05c,12'h05b,12'h059,12'h057,12'h055,12'h053,12'h052,
        12'h050,12'h04e,12'h04d,12'h04b,12'h04a,12'h048,12'h046,12'h045,
        12'h043,12'h042,12'h040,12'h03f,12'h03e,12'h03c,12'h03b,12'h039,
        12'h038,12'h037,12'h035,12'h034,12'h033,12'h031,12'h030,12'h02f,
        12'h02e,12'h02d,12'h02b,12'h02a,12'h029,12'h028,12'h027,12'h026,
        12'h025,12'h024,12'h023,12'h022,12'h021,12'h020,12'h01f,12'h01e,
        12'h01d,12'h01c,12'h01b,12'h01a,12'h019,12'h018,12'h017,12'h017,
        12'h016,12'h015,12'h014,12'h014,12'h013,12'h012,12'h011,12'h011,
        12'h010,12'h00f,12'h00f,12'h00e,12'h00d,12'h00d,12'h00c,12'h00c,
        12'h00b,12'h00a,12'h00a,12'h009,12'h009,12'h008,12'h008,12'h007,
        12'h007,12'h007,12'h006,12'h006,12'h005,12'h005,12'h005,12'h004,
        12'h004,12'h004,12'h003,12'h003,12'h003,12'h002,12'h002,12'h002,
        12'h002,12'h001,12'h001,12'h001,12'h001,12'h001,12'h001,12'h001,
        12'h000,12'h000,12'h000,12'h000,12'h000,12'h000,12'h000,12'h000
    };

    // Entry i is round(2048 * 2^(-(i+1)/256)), built in Q63 fixed point at
    // elaboration: the 256th root of one half by repeated square roots, then
    // successive powers of it.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t     rom;
        logic [63:0]  root;
        logic [63:0]  pwr;
        logic [63:0]  y;
        logic [63:0]  trial;
        logic [127:0] target;
        logic [127:0] prod;
        logic [63:0]  rounded;
        root = 64'd1 << 62;
        pwr  = 64'd1 << 63;
        for (int i = 0; i < 8; i++) begin
            target = 128'(root) << 63;
            y      = 64'd0;
            for (int b = 62; b >= 0; b--) begin
                trial = y | (64'd1 << b);
                prod  = 128'(trial) * 128'(trial);
                if (prod <= target) begin
                    y = trial;
                end
            end
            root = y;
        end
        for (int i = 0; i < 256; i++) begin
            prod    = 128'(pwr) * 128'(root);
            pwr     = prod[126:63];
            rounded = (pwr + (64'd1 << 51)) >> 52;
            rom[i]  = rounded[EXP_W-1:0];
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== hw/rtl/fm_two_operator_channel_output.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-operator FM channel output
// Modulator with per-channel self-feedback driving a carrier, one sample
// per request.
// ---------------------------------------------------------------------------
//  Channel   Direction  Ports                         Width of tdata
//  s_        in         s_tvalid s_tready s_tdata     56
//  m_        out        m_tvalid m_tready m_tdata     16
//
// Three register stages: input request, modulator result, channel sample.
// A request is accepted every cycle while the output is taken; it passes
// through the input, modulator and sample registers on its way to m_tvalid.
// The feedback history is read and written in the modulator stage, so
// back-to-back requests on one channel see each other's outputs.
// Reset clears the feedback history and all stage valid flags.
// A stall at m_tready fills the stages before s_tready falls.
// ---------------------------------------------------------------------------
module fm_two_operator_channel_output
    import fmop_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // chan_index, mod_phase, car_phase, mod_atten, car_atten, lfo_depth,
    // mod_am_on, car_am_on, mod_half_sine, car_half_sine, fb_level, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // chan_echo, chan_sample, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                  s1_valid_reg;
    logic [IN_TDATA_W-1:0] s1_data_reg;

    logic                         s2_valid_reg;
    logic [CHAN_W-1:0]            s2_chan_reg;
    logic [PHASE_W-1:0]           s2_phase_reg;
    logic [ATTEN_SUM_W-1:0]       s2_atten_reg;
    logic                         s2_half_sine_reg;
    logic signed [OP_OUT_W-1:0]   s2_mod_reg;

    logic                         out_valid_reg;
    logic [CHAN_W-1:0]            out_chan_reg;
    logic signed [SAMPLE_W-1:0]   out_sample_reg;

    logic signed [OP_OUT_W-1:0] hist_last_reg [CHANNELS];
    logic signed [OP_OUT_W-1:0] hist_prev_reg [CHANNELS];

    logic ready_out;
    logic ready_s2;
    logic ready_s1;
    logic move_s1;
    logic move_s2;

    logic [CHAN_W-1:0]      in_chan;
    logic [PHASE_W-1:0]     in_mod_phase;
    logic [PHASE_W-1:0]     in_car_phase;
    logic [ATTEN_IN_W-1:0]  in_mod_atten;
    logic [ATTEN_IN_W-1:0]  in_car_atten;
    logic [LFO_W-1:0]       in_lfo;
    logic                   in_mod_am;
    logic                   in_car_am;
    logic                   in_mod_hs;
    logic                   in_car_hs;
    logic [FB_W-1:0]        in_fb;

    logic                        chan_ok;
    logic [IDX_W-1:0]            chan_idx;
    logic signed [OP_OUT_W-1:0]  hist_last;
    logic signed [OP_OUT_W-1:0]  hist_prev;
    logic signed [FB_SUM_W-1:0]  fb_sum;
    logic signed [FB_SUM_W-1:0]  fb_shifted;
    logic [3:0]                  fb_shift;
    logic [PHASE_W-1:0]          fb_offset;
    logic [ATTEN_SUM_W-1:0]      mod_atten_sum;
    logic [ATTEN_SUM_W-1:0]      car_atten_sum;

    op_req_t                     mod_req;
    op_req_t                     car_req;
    logic signed [OP_OUT_W-1:0]  mod_out;
    logic signed [OP_OUT_W-1:0]  car_out;

    assign ready_out = !out_valid_reg || m_tready;
    assign ready_s2  = !s2_valid_reg || ready_out;
    assign ready_s1  = !s1_valid_reg || ready_s2;
    assign s_tready  = ready_s1;
    assign move_s1   = s1_valid_reg && ready_s2;
    assign move_s2   = s2_valid_reg && ready_out;

    assign in_chan      = s1_data_reg[3:0];
    assign in_mod_phase = s1_data_reg[13:4];
    assign in_car_phase = s1_data_reg[23:14];
    assign in_mod_atten = s1_data_reg[32:24];
    assign in_car_atten = s1_data_reg[41:33];
    assign in_lfo       = s1_data_reg[45:42];
    assign in_mod_am    = s1_data_reg[46];
    assign in_car_am    = s1_data_reg[47];
    assign in_mod_hs    = s1_data_reg[48];
    assign in_car_hs    = s1_data_reg[49];
    assign in_fb        = s1_data_reg[52:50];

    always_comb begin
        chan_ok   = CHAN_CMP_W'(in_chan) < CHAN_CMP_W'(CHANNELS);
        chan_idx  = IDX_W'(in_chan);
        hist_last = chan_ok ? hist_last_reg[chan_idx] : '0;
        hist_prev = chan_ok ? hist_prev_reg[chan_idx] : '0;
        fb_sum    = FB_SUM_W'(hist_last) + FB_SUM_W'(hist_prev);
        fb_shift  = FB_SHIFT_BASE - {1'b0, in_fb};
        fb_shifted = fb_sum >>> fb_shift;
        fb_offset = (in_fb == '0) ? '0 : fb_shifted[PHASE_W-1:0];
        mod_atten_sum = ATTEN_SUM_W'(in_mod_atten)
                      + (in_mod_am ? ATTEN_SUM_W'(in_lfo) : '0);
        car_atten_sum = ATTEN_SUM_W'(in_car_atten)
                      + (in_car_am ? ATTEN_SUM_W'(in_lfo) : '0);

        mod_req.phase     = in_mod_phase;
        mod_req.offset    = fb_offset;
        mod_req.atten     = mod_atten_sum;
        mod_req.half_sine = in_mod_hs;

        car_req.phase     = s2_phase_reg;
        car_req.offset    = s2_mod_reg[PHASE_W:1];
        car_req.atten     = s2_atten_reg;
        car_req.half_sine = s2_half_sine_reg;
    end

    fmop_operator u_mod_op (
        .req    (mod_req),
        .op_out (mod_out)
    );

    fmop_operator u_car_op (
        .req    (car_req),
        .op_out (car_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                hist_last_reg[i] <= '0;
                hist_prev_reg[i] <= '0;
            end
        end else begin
            if (ready_s1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (ready_s2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready_out) begin
                out_valid_reg <= s2_valid_reg;
            end
            if (move_s1 && chan_ok) begin
                hist_prev_reg[chan_idx] <= hist_last;
                hist_last_reg[chan_idx] <= mod_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_s1 && s_tvalid) begin
            s1_data_reg <= s_tdata;
        end
        if (move_s1) begin
            s2_chan_reg      <= in_chan;
            s2_phase_reg     <= in_car_phase;
            s2_atten_reg     <= car_atten_sum;
            s2_half_sine_reg <= in_car_hs;
            s2_mod_reg       <= mod_out;
        end
        if (move_s2) begin
            out_chan_reg   <= s2_chan_reg;
            out_sample_reg <= car_out[OP_OUT_W-1:SAMPLE_LSB];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_sample_reg, out_chan_reg};

endmodule

// ===== hw/rtl/fmop_operator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FM operator
// Log-sine lookup, attenuation add and exp conversion for one operator.
// ---------------------------------------------------------------------------
module fmop_operator
    import fmop_pkg::*;
(
    input  op_req_t                     req,
    output logic signed [OP_OUT_W-1:0]  op_out
);

    logic [ATTEN_W-1:0]   atten;
    logic [PHASE_W-1:0]   phase_sum;
    logic                 sign;
    logic [7:0]           idx;
    logic [LSIN_W-1:0]    lsin;
    logic                 neg;
    logic [LOG_SUM_W-1:0] log_sum;
    logic [MAG_W-1:0]     mag;

    always_comb begin
        atten     = (req.atten > ATTEN_SUM_W'(ATTEN_MAX)) ? ATTEN_MAX
                                                          : req.atten[ATTEN_W-1:0];
        phase_sum = req.phase + req.offset;
        sign      = phase_sum[PHASE_W-1];
        idx       = phase_sum[8] ? ~phase_sum[7:0] : phase_sum[7:0];
        if (sign && req.half_sine) begin
            lsin = LSIN_SILENT;
            neg  = 1'b0;
        end else begin
            lsin = LOGSIN_ROM[idx];
            neg  = sign;
        end
        log_sum = LOG_SUM_W'(lsin) + {2'b00, atten, 4'b0000};
        mag     = {EXP_ROM[log_sum[7:0]], 2'b00} >> log_sum[LOG_SUM_W-1:8];
        op_out  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule

// ===== tb/sv/fm_two_operator_channel_output_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-operator FM channel output testbench
// Sends a short table of hand-picked requests and then random voice-like,
// field-edge and noisy requests under four idling patterns on both stream
// ports. A behavioural model of the modulator, its per-channel feedback
// history and the carrier predicts every sample but the pinned ones of the
// table, and the samples are compared field by field in order of arrival.
// ---------------------------------------------------------------------------
module fm_two_operator_channel_output_tb;
    import fmop_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PER_MODE = 408;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HEAVY_PCT       = 84;
    localparam int LIGHT_PCT       = 12;
    localparam int DIRECTED_ROWS   = 22;

    localparam logic [6:0]  ATTEN_CEIL = 7'd127;
    localparam logic [11:0] LOG_SILENT = 12'hFFF;

    localparam logic [8:0] ATTEN_EDGES [4] = '{9'd0, 9'd127, 9'd128, 9'd511};
    localparam logic [9:0] PHASE_EDGES [8] = '{10'd0, 10'd255, 10'd256, 10'd511,
                                               10'd512, 10'd767, 10'd768, 10'd1023};

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    // Declared from the top bit down, so the struct packs straight into s_tdata.
    typedef struct packed {
        logic [2:0] fb_level;
        logic       car_half_sine;
        logic       mod_half_sine;
        logic       car_am_on;
        logic       mod_am_on;
        logic [3:0] lfo_depth;
        logic [8:0] car_atten;
        logic [8:0] mod_atten;
        logic [9:0] car_phase;
        logic [9:0] mod_phase;
        logic [3:0] chan_index;
    } fm_req_t;

    typedef struct packed {
        logic [3:0]        chan;
        logic signed [8:0] sample;
    } fm_sample_t;

    typedef struct {
        int chan;
        int mod_phase;
        int car_phase;
        int mod_atten;
        int car_atten;
        int lfo;
        int mod_am;
        int car_am;
        int mod_half;
        int car_half;
        int fb;
        int pinned;
        int pin_sample;
    } stim_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    idle_mode_e        idle_mode      = IDLE_NONE;
    logic              req_pinned     = 1'b0;
    logic signed [8:0] req_pin_sample = '0;

    int accepted_count   = 0;
    int checked_count    = 0;
    int mismatch_count   = 0;
    int stray_chan_count = 0;

    logic signed [13:0] mod_last [CHANNELS_DEF] = '{default: '0};
    logic signed [13:0] mod_prev [CHANNELS_DEF] = '{default: '0};
    logic [10:0]        pow2_lut [256];
    fm_sample_t         expected_samples [$];

    logic [11:0] sine_log [256] = '{
        12'h859, 12'h6c3, 12'h607, 12'h58b, 12'h52e, 12'h4e4, 12'h4a6, 12'h471,
        12'h443, 12'h41a, 12'h3f5, 12'h3d3, 12'h3b5, 12'h398, 12'h37e, 12'h365,
        12'h34e, 12'h339, 12'h324, 12'h311, 12'h2ff, 12'h2ed, 12'h2dc, 12'h2cd,
        12'h2bd, 12'h2af, 12'h2a0, 12'h293, 12'h286, 12'h279, 12'h26d, 12'h261,
        12'h256, 12'h24b, 12'h240, 12'h236, 12'h22c, 12'h222, 12'h218, 12'h20f,
        12'h206, 12'h1fd, 12'h1f5, 12'h1ec, 12'h1e4, 12'h1dc, 12'h1d4, 12'h1cd,
        12'h1c5, 12'h1be, 12'h1b7, 12'h1b0, 12'h1a9, 12'h1a2, 12'h19b, 12'h195,
        12'h18f, 12'h188, 12'h182, 12'h17c, 12'h177, 12'h171, 12'h16b, 12'h166,
        12'h160, 12'h15b, 12'h155, 12'h150, 12'h14b, 12'h146, 12'h141, 12'h13c,
        12'h137, 12'h133, 12'h12e, 12'h129, 12'h125, 12'h121, 12'h11c, 12'h118,
        12'h114, 12'h10f, 12'h10b, 12'h107, 12'h103, 12'h0ff, 12'h0fb, 12'h0f8,
        12'h0f4, 12'h0f0, 12'h0ec, 12'h0e9, 12'h0e5, 12'h0e2, 12'h0de, 12'h0db,
        12'h0d7, 12'h0d4, 12'h0d1, 12'h0cd, 12'h0ca, 12'h0c7, 12'h0c4, 12'h0c1,
        12'h0be, 12'h0bb, 12'h0b8, 12'h0b5, 12'h0b2, 12'h0af, 12'h0ac, 12'h0a9,
        12'h0a7, 12'h0a4, 12'h0a1, 12'h09f, 12'h09c, 12'h099, 12'h097, 12'h094,
        12'h092, 12'h08f, 12'h08d, 12'h08a, 12'h088, 12'h086, 12'h083, 12'h081,
        12'h07f, 12'h07d, 12'h07a, 12'h078, 12'h076, 12'h074, 12'h072, 12'h070,
        12'h06e, 12'h06c, 12'h06a, 12'h068, 12'h066, 12'h064, 12'h062, 12'h060,
        12'h05e, 12'h05c, 12'h05b, 12'h059, 12'h057, 12'h055, 12'h053, 12'h052,
        12'h050, 12'h04e, 12'h04d, 12'h04b, 12'h04a, 12'h048, 12'h046, 12'h045,
        12'h043, 12'h042, 12'h040, 12'h03f, 12'h03e, 12'h03c, 12'h03b, 12'h039,
        12'h038, 12'h037, 12'h035, 12'h034, 12'h033, 12'h031, 12'h030, 12'h02f,
        12'h02e, 12'h02d, 12'h02b, 12'h02a, 12'h029, 12'h028, 12'h027, 12'h026,
        12'h025, 12'h024, 12'h023, 12'h022, 12'h021, 12'h020, 12'h01f, 12'h01e,
        12'h01d, 12'h01c, 12'h01b, 12'h01a, 12'h019, 12'h018, 12'h017, 12'h017,
        12'h016, 12'h015, 12'h014, 12'h014, 12'h013, 12'h012, 12'h011, 12'h011,
        12'h010, 12'h00f, 12'h00f, 12'h00e, 12'h00d, 12'h00d, 12'h00c, 12'h00c,
        12'h00b, 12'h00a, 12'h00a, 12'h009, 12'h009, 12'h008, 12'h008, 12'h007,
        12'h007, 12'h007, 12'h006, 12'h006, 12'h005, 12'h005, 12'h005, 12'h004,
        12'h004, 12'h004, 12'h003, 12'h003, 12'h003, 12'h002, 12'h002, 12'h002,
        12'h002, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001, 12'h001,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000
    };

    fm_two_operator_channel_output dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // chan_index, mod_phase, car_phase, mod_atten, car_atten, lfo_depth,
        // mod_am_on, car_am_on, mod_half_sine, car_half_sine, fb_level, zero pad
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // chan_echo, chan_sample, zero pad
        .m_tdata  (m_tdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic logic signed [13:0] operator_value(input logic [9:0] phase,
                                                          input logic [9:0] offset,
                                                          input logic [9:0] atten_sum,
                                                          input logic       half_sine);
        logic [6:0]  att;
        logic [9:0]  p;
        logic [7:0]  idx;
        logic [11:0] lsin;
        logic        neg;
        logic [12:0] c;
        logic [12:0] mag;
        att  = (atten_sum > 10'd127) ? ATTEN_CEIL : atten_sum[6:0];
        p    = phase + offset;
        idx  = p[8] ? ~p[7:0] : p[7:0];
        lsin = sine_log[idx];
        neg  = p[9];
        if (p[9] && half_sine) begin
            lsin = LOG_SILENT;
            neg  = 1'b0;
        end
        c   = {1'b0, lsin} + {2'b00, att, 4'b0000};
        mag = {pow2_lut[c[7:0]], 2'b00} >> c[12:8];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // Works out one channel sample and moves that channel's feedback history on.
    function automatic fm_sample_t voice_sample(input fm_req_t r);
        logic               in_range;
        logic signed [13:0] last;
        logic signed [13:0] prev;
        logic signed [14:0] fb_sum;
        logic signed [14:0] fb_val;
        logic signed [13:0] mod_val;
        logic signed [13:0] car_val;
        fm_sample_t         res;
        in_range = r.chan_index < 4'(CHANNELS_DEF);
        last     = in_range ? mod_last[r.chan_index] : '0;
        prev     = in_range ? mod_prev[r.chan_index] : '0;
        fb_val   = '0;
        if (r.fb_level != 3'd0) begin
            fb_sum = {last[13], last} + {prev[13], prev};
            fb_val = fb_sum >>> (4'd10 - {1'b0, r.fb_level});
        end
        mod_val = operator_value(r.mod_phase, fb_val[9:0],
                                 {1'b0, r.mod_atten} +
                                 {6'd0, (r.mod_am_on ? r.lfo_depth : 4'd0)},
                                 r.mod_half_sine);
        if (in_range) begin
            mod_prev[r.chan_index] = last;
            mod_last[r.chan_index] = mod_val;
        end
        car_val = operator_value(r.car_phase, mod_val[10:1],
                                 {1'b0, r.car_atten} +
                                 {6'd0, (r.car_am_on ? r.lfo_depth : 4'd0)},
                                 r.car_half_sine);
        res.chan   = r.chan_index;
        res.sample = car_val[13:5];
        return res;
    endfunction

    // Mostly voice-like requests with live feedback on a few channels, then
    // requests at the field edges, then plain noise over every bit.
    function automatic fm_req_t random_request();
        logic [63:0] bits;
        fm_req_t     r;
        int          kind;
        bits = {$urandom(), $urandom()};
        r    = bits[52:0];
        kind = $urandom_range(99);
        if (kind < 65) begin
            r.chan_index = ($urandom_range(1) == 1) ? 4'($urandom_range(2))
                                                    : 4'($urandom_range(8));
            r.mod_atten  = 9'($urandom_range(63));
            r.car_atten  = 9'($urandom_range(127));
            r.fb_level   = 3'($urandom_range(7, 1));
        end else if (kind < 80) begin
            r.mod_atten = ATTEN_EDGES[$urandom_range(3)];
            r.car_atten = ATTEN_EDGES[$urandom_range(3)];
            r.mod_phase = PHASE_EDGES[$urandom_range(7)];
            r.car_phase = PHASE_EDGES[$urandom_range(7)];
            r.lfo_depth = ($urandom_range(1) == 1) ? 4'd15 : 4'd0;
        end
        return r;
    endfunction

    task automatic send_request(input fm_req_t req, input logic pinned,
                                input logic signed [8:0] pin_sample);
        int seen;
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SENDER) ? HEAVY_PCT :
                   (idle_mode == IDLE_BOTH) ? LIGHT_PCT : 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid       <= 1'b1;
        s_tdata        <= {3'b000, req};
        req_pinned     = pinned;
        req_pin_sample = pin_sample;
        seen           = accepted_count;
        do @(negedge aclk); while (accepted_count == seen);
    endtask

    always @(negedge aclk) begin
        if (idle_mode == IDLE_RECEIVER) begin
            m_tready <= $urandom_range(99) >= HEAVY_PCT;
        end else if (idle_mode == IDLE_BOTH) begin
            m_tready <= $urandom_range(99) >= LIGHT_PCT;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        fm_sample_t got;
        fm_sample_t want;
        fm_sample_t predicted;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.chan   = m_tdata[3:0];
                got.sample = m_tdata[12:4];
                if (expected_samples.size() == 0) begin
                    $display("%0t: sample arrived with none expected, actual chan %0d sample %0d",
                             $time, got.chan, $signed(got.sample));
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    checked_count++;
                    if (got.chan !== want.chan) begin
                        $display("%0t: chan_echo mismatch, expected %0d, actual %0d",
                                 $time, want.chan, got.chan);
                        mismatch_count++;
                    end
                    if (got.sample !== want.sample) begin
                        $display("%0t: chan_sample mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.sample), $signed(got.sample));
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = voice_sample(s_tdata[52:0]);
                if (req_pinned) begin
                    predicted.sample = req_pin_sample;
                end
                expected_samples.insert(expected_samples.size(), predicted);
                accepted_count++;
                if (s_tdata[3:0] >= 4'(CHANNELS_DEF)) begin
                    stray_chan_count++;
                end
            end
        end
    end

    initial begin
        stim_row_t directed [DIRECTED_ROWS];
        fm_req_t   req;
        for (int i = 0; i < 256; i++) begin
            pow2_lut[i] = 11'($rtoi(2048.0 * 2.0 ** (-(i + 1) / 256.0) + 0.5));
        end
        // chan, mod/car phase, mod/car atten, lfo, mod/car am, mod/car half,
        // feedback, pinned, pinned sample. Rows with the modulator fully
        // attenuated and no feedback leave the carrier unmodulated.
        directed = '{
            '{0,    0,  255, 511,   0,  0, 0, 0, 0, 0, 0, 1,  255},
            '{0,    0,  767, 511,   0,  0, 0, 0, 0, 0, 0, 1, -256},
            '{0,    0,  768, 511,   0,  0, 0, 0, 0, 0, 0, 1, -256},
            '{1,    0,  256, 511,   0,  0, 0, 0, 0, 0, 0, 1,  255},
            '{1,    0,  512, 511,   0,  0, 0, 0, 0, 1, 0, 1,    0},
            '{1,    0,    0, 511, 511,  0, 0, 0, 0, 0, 0, 1,    0},
            '{0,    0,    0,   0,   0,  0, 0, 0, 0, 0, 0, 0,    0},
            '{8,  255,    0,   0,   0,  0, 0, 0, 0, 0, 7, 0,    0},
            '{8,  255,    0,   0,   0,  0, 0, 0, 0, 0, 7, 0,    0},
            '{8,  300,  100,   0,  20,  0, 0, 0, 0, 0, 7, 0,    0},
            '{8,  700,  900,   0,   0,  0, 0, 0, 0, 0, 1, 0,    0},
            '{9,  255,    0,   0,   0,  0, 0, 0, 0, 0, 7, 0,    0},
            '{15, 1023, 1023, 511, 511, 15, 1, 1, 1, 1, 7, 0,    0},
            '{2,  128,  255, 120, 120, 15, 1, 1, 0, 0, 3, 0,    0},
            '{2,  128,  255, 100,   0, 15, 1, 0, 0, 0, 3, 0,    0},
            '{3,  600,  300,   0,   0,  0, 0, 0, 1, 0, 5, 0,    0},
            '{3,  600,  300,   0,   0,  0, 0, 0, 1, 1, 5, 0,    0},
            '{4, 1023, 1023,   0,   0,  0, 0, 0, 0, 0, 6, 0,    0},
            '{4,  512,  511, 127, 127,  8, 1, 1, 0, 0, 2, 0,    0},
            '{4,  512,  511, 128,   0,  0, 0, 0, 0, 0, 4, 0,    0},
            '{8,  255,    0,   0,   0,  0, 0, 0, 0, 0, 7, 0,    0},
            '{5,    0,    0,   0,   0, 15, 0, 0, 0, 0, 7, 0,    0}
        };
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i]) begin
            req.chan_index    = 4'(directed[i].chan);
            req.mod_phase     = 10'(directed[i].mod_phase);
            req.car_phase     = 10'(directed[i].car_phase);
            req.mod_atten     = 9'(directed[i].mod_atten);
            req.car_atten     = 9'(directed[i].car_atten);
            req.lfo_depth     = 4'(directed[i].lfo);
            req.mod_am_on     = 1'(directed[i].mod_am);
            req.car_am_on     = 1'(directed[i].car_am);
            req.mod_half_sine = 1'(directed[i].mod_half);
            req.car_half_sine = 1'(directed[i].car_half);
            req.fb_level      = 3'(directed[i].fb);
            send_request(req, 1'(directed[i].pinned), 9'(directed[i].pin_sample));
        end
        for (int m = 0; m < 4; m++) begin
            idle_mode = idle_mode_e'(m);
            repeat (RANDOM_PER_MODE) send_request(random_request(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        idle_mode = IDLE_NONE;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d directed and %0d random requests under four idling patterns.",
                 DIRECTED_ROWS, 4 * RANDOM_PER_MODE);
        $display("%0d samples checked, %0d requests named a channel with no feedback store.",
                 checked_count, stray_chan_count);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Timeout with %0d samples still outstanding.", expected_samples.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
